### src/ed_pkg.sv
// Shared types and constants for the edit distance engine.
`timescale 1ns / 1ps
package ed_pkg;

	// Payload widths of the two channels.
	localparam int CHAR_W = 8;
	localparam int OP_W   = 2;
	localparam int DIST_W = 7;

	// Operation codes carried by an input transaction.
	localparam logic [OP_W-1:0] OP_FIRST  = 2'd0;
	localparam logic [OP_W-1:0] OP_SECOND = 2'd1;
	localparam logic [OP_W-1:0] OP_END    = 2'd2;

	// Cost of one insertion, deletion or substitution.
	localparam int EDIT_COST = 1;

	// Control that travels with the data from one cell to the next.
	typedef struct packed {
		logic byte_vld;  // a second-string byte updates the column
		logic tok;       // end marker collects the distance and clears cells
	} cell_ctl_t;

endpackage

### src/ed_if.sv
// Valid/ready channel interfaces for the request and result streams.
`timescale 1ns / 1ps
interface ed_req_if;
	logic                            valid;
	logic                            ready;
	logic [ed_pkg::OP_W-1:0]   operation;
	logic [ed_pkg::CHAR_W-1:0] character;

	modport source (output valid, output operation, output character, input ready);
	modport sink   (input valid, input operation, input character, output ready);
endinterface

interface ed_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [ed_pkg::DIST_W-1:0] distance;
	logic                            overflow;

	modport source (output valid, output distance, output overflow, input ready);
	modport sink   (input valid, input distance, input overflow, output ready);
endinterface

### src/ed_cell.sv
// One cell of the systolic row: holds one first-string byte and its column entry.
`timescale 1ns / 1ps
module ed_cell #(
	parameter int VAL_W = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load_en,
	input  logic [ed_pkg::CHAR_W-1:0] load_chr,
	input  logic [VAL_W-1:0]          load_val,
	input  ed_pkg::cell_ctl_t         in_ctl,
	input  logic [ed_pkg::CHAR_W-1:0] in_chr,
	input  logic [VAL_W-1:0]          in_left,
	input  logic [VAL_W-1:0]          in_diag,
	output ed_pkg::cell_ctl_t         out_ctl,
	output logic [ed_pkg::CHAR_W-1:0] out_chr,
	output logic [VAL_W-1:0]          out_left,
	output logic [VAL_W-1:0]          out_diag
);
	import ed_pkg::*;

	logic              vld_q;
	logic [CHAR_W-1:0] chr_q;
	logic [VAL_W-1:0]  val_q;
	cell_ctl_t         ctl_q;
	logic [CHAR_W-1:0] pass_chr_q;
	logic [VAL_W-1:0]  left_q;
	logic [VAL_W-1:0]  diag_q;

	logic [VAL_W:0]    cost_up;
	logic [VAL_W:0]    cost_left;
	logic [VAL_W:0]    cost_diag;
	logic [VAL_W:0]    cost_min;
	logic [VAL_W-1:0]  new_val;

	// Minimum of the three ways into this entry of the column.
	always_comb begin
		cost_up   = {1'b0, val_q} + (VAL_W+1)'(EDIT_COST);
		cost_left = {1'b0, in_left} + (VAL_W+1)'(EDIT_COST);
		cost_diag = {1'b0, in_diag};
		if (chr_q != in_chr) begin
			cost_diag = cost_diag + (VAL_W+1)'(EDIT_COST);
		end
		cost_min = (cost_up < cost_left) ? cost_up : cost_left;
		if (cost_diag < cost_min) begin
			cost_min = cost_diag;
		end
		new_val = cost_min[VAL_W-1:0];
	end

	// Stored byte and column entry; the end marker empties the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load_en) begin
			vld_q <= 1'b1;
		end else if (in_ctl.tok) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			chr_q <= load_chr;
			val_q <= load_val;
		end else if (in_ctl.byte_vld && vld_q) begin
			val_q <= new_val;
		end
	end

	// Control moves to the next cell in every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= in_ctl;
		end
	end

	// Handed on: new entry as left, old as diagonal; at the marker, own entry as left.
	always_ff @(posedge clk) begin
		pass_chr_q <= in_chr;
		if (vld_q && in_ctl.byte_vld) begin
			left_q <= new_val;
			diag_q <= val_q;
		end else if (vld_q && in_ctl.tok) begin
			left_q <= val_q;
			diag_q <= in_diag;
		end else begin
			left_q <= in_left;
			diag_q <= in_diag;
		end
	end

	assign out_ctl  = ctl_q;
	assign out_chr  = pass_chr_q;
	assign out_left = left_q;
	assign out_diag = diag_q;

endmodule

### src/edit_distance_engine.sv
// One first- or second-string byte is accepted per cycle while the input is open (not busy, skid register empty).
// An end transaction sends the end marker through every cell; its result is registered once the marker has
// left the row, and the input stays closed until then.
// A finished result waits in an output register and a skid register behind it.
// Reset (arst_n low, asynchronous) empties both strings, clears the overflow flag and
// the valid flags of the result registers; the row of cells is ready once reset is released.
`timescale 1ns / 1ps
module edit_distance_engine #(
	parameter int MAX_LEN = 64
) (
	input logic   clk,
	input logic   arst_n,
	ed_req_if.sink   req,
	ed_rsp_if.source rsp
);
	import ed_pkg::*;

	localparam int VW = $clog2(MAX_LEN + 1);
	localparam logic [VW-1:0] MAX_V = VW'(MAX_LEN);

	logic [VW-1:0] first_len_q;
	logic [VW-1:0] second_len_q;
	logic          ovf_q;
	logic          ovf_pend_q;
	logic          busy_q;

	logic              out_vld_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_ovf_q;
	logic              skid_vld_q;
	logic [DIST_W-1:0] skid_dist_q;
	logic              skid_ovf_q;

	logic accept;
	logic is_first;
	logic is_second;
	logic is_end;
	logic do_load;
	logic do_stream;
	logic exit_tok;
	logic out_take;

	cell_ctl_t         ctl_w  [0:MAX_LEN];
	logic [CHAR_W-1:0] chr_w  [0:MAX_LEN];
	logic [VW-1:0]     left_w [0:MAX_LEN];
	logic [VW-1:0]     diag_w [0:MAX_LEN];
	logic [MAX_LEN-1:0] load_en;
	logic [VW+DIST_W-1:0] exit_ext;

	// Request decode.
	assign req.ready = !busy_q && !skid_vld_q;
	assign accept    = req.valid && req.ready;

	always_comb begin
		is_first  = 1'b0;
		is_second = 1'b0;
		is_end    = 1'b0;
		case (req.operation)
			OP_FIRST:  is_first  = 1'b1;
			OP_SECOND: is_second = 1'b1;
			OP_END:    is_end    = 1'b1;
			default: begin
				is_first  = 1'b0;
				is_second = 1'b0;
				is_end    = 1'b0;
			end
		endcase
	end

	assign do_load   = accept && is_first && (first_len_q != MAX_V) && (second_len_q == '0);
	assign do_stream = accept && is_second && (second_len_q != MAX_V);

	// Lengths and the overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q  <= '0;
			second_len_q <= '0;
			ovf_q        <= 1'b0;
			ovf_pend_q   <= 1'b0;
		end else if (accept && is_end) begin
			first_len_q  <= '0;
			second_len_q <= '0;
			ovf_q        <= 1'b0;
			ovf_pend_q   <= ovf_q;
		end else if (accept) begin
			if (do_load) begin
				first_len_q <= first_len_q + VW'(1);
			end
			if (do_stream) begin
				second_len_q <= second_len_q + VW'(1);
			end
			if ((is_first && !do_load) || (is_second && !do_stream)) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Column entry zero is the second-string length; it feeds the head of the row.
	always_comb begin
		ctl_w[0].byte_vld = do_stream;
		ctl_w[0].tok      = accept && is_end;
		chr_w[0]          = req.character;
		diag_w[0]         = second_len_q;
		left_w[0]         = do_stream ? (second_len_q + VW'(1)) : second_len_q;
	end

	// Row of cells, one per first-string position.
	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		assign load_en[i] = do_load && (first_len_q == VW'(i));

		ed_cell #(
			.VAL_W (VW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load_en  (load_en[i]),
			.load_chr (req.character),
			.load_val (VW'(i + 1)),
			.in_ctl   (ctl_w[i]),
			.in_chr   (chr_w[i]),
			.in_left  (left_w[i]),
			.in_diag  (diag_w[i]),
			.out_ctl  (ctl_w[i+1]),
			.out_chr  (chr_w[i+1]),
			.out_left (left_w[i+1]),
			.out_diag (diag_w[i+1])
		);
	end

	// The end marker leaves the row carrying the last valid column entry.
	assign exit_tok = ctl_w[MAX_LEN].tok;
	assign exit_ext = {{DIST_W{1'b0}}, left_w[MAX_LEN]};
	assign out_take = out_vld_q && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept && is_end) begin
			busy_q <= 1'b1;
		end else if (exit_tok) begin
			busy_q <= 1'b0;
		end
	end

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (exit_tok) begin
			if (out_vld_q && !out_take) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (out_take) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exit_tok) begin
			if (out_vld_q && !out_take) begin
				skid_dist_q <= exit_ext[DIST_W-1:0];
				skid_ovf_q  <= ovf_pend_q;
			end else begin
				out_dist_q <= exit_ext[DIST_W-1:0];
				out_ovf_q  <= ovf_pend_q;
			end
		end else if (out_take && skid_vld_q) begin
			out_dist_q <= skid_dist_q;
			out_ovf_q  <= skid_ovf_q;
		end
	end

	assign rsp.valid    = out_vld_q;
	assign rsp.distance = out_dist_q;
	assign rsp.overflow = out_ovf_q;

endmodule

### test/edit_distance_engine_tb.sv
// Self-checking testbench for the edit distance engine, with its own predictor of the distance.
`timescale 1ns / 1ps
module edit_distance_engine_tb;
	import ed_pkg::*;

	localparam int MAX_LEN        = 64;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int RANDOM_ITEMS   = 140;
	localparam int DRAIN_CYCLES   = MAX_LEN + 8;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} dist_result_t;

	logic clk;
	logic arst_n;

	ed_req_if req_ch ();
	ed_rsp_if rsp_ch ();

	edit_distance_engine #(
		.MAX_LEN(MAX_LEN)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Distances still owed by the engine, oldest first.
	dist_result_t distance_expected_q[$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int accepted_count = 0;
	bit idle_on        = 1'b0;
	int rsp_hold_left  = 0;
	int rsp_stall_left = 0;

	// Predictor state: the first string, both lengths and the cost column.
	logic [CHAR_W-1:0] first_chars[MAX_LEN];
	int                first_len;
	int                second_len;
	int                cost_col[MAX_LEN + 1];
	bit                bytes_dropped;

	function automatic void clear_strings();
		first_len     = 0;
		second_len    = 0;
		bytes_dropped = 1'b0;
		for (int i = 0; i <= MAX_LEN; i++)
			cost_col[i] = i;
	endfunction

	// Applies one accepted transaction to the predictor and queues any distance it emits.
	function automatic void track_edit_distance(input logic [OP_W-1:0] op,
	                                            input logic [CHAR_W-1:0] ch);
		int           diag;
		int           above;
		int           sub;
		int           best;
		dist_result_t res;
		case (op)
			OP_FIRST: begin
				// A first-string byte is dropped once the string is full or the column has moved on.
				if (first_len >= MAX_LEN || second_len != 0) begin
					bytes_dropped = 1'b1;
				end else begin
					first_chars[first_len] = ch;
					first_len++;
					cost_col[first_len] = first_len;
				end
			end
			OP_SECOND: begin
				if (second_len >= MAX_LEN) begin
					bytes_dropped = 1'b1;
				end else begin
					diag = cost_col[0];
					second_len++;
					cost_col[0] = second_len;
					for (int i = 1; i <= first_len; i++) begin
						above = cost_col[i];
						sub   = (first_chars[i - 1] == ch) ? 0 : EDIT_COST;
						best  = above + EDIT_COST;
						if (cost_col[i - 1] + EDIT_COST < best)
							best = cost_col[i - 1] + EDIT_COST;
						if (diag + sub < best)
							best = diag + sub;
						cost_col[i] = best;
						diag        = above;
					end
				end
			end
			OP_END: begin
				res.distance = DIST_W'(cost_col[first_len]);
				res.overflow = bytes_dropped;
				distance_expected_q = {distance_expected_q, res};
				clear_strings();
			end
			default: begin
				// The unused operation leaves everything as it was.
			end
		endcase
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 8);
		if (r < 90)
			return $urandom_range(9, 32);
		if (r < 96)
			return $urandom_range(33, MAX_LEN);
		return $urandom_range(MAX_LEN, MAX_LEN + 4);
	endfunction

	// A small alphabet makes matching bytes common.
	function automatic logic [CHAR_W-1:0] pick_char(input bit narrow);
		if (narrow)
			return 8'h61 + CHAR_W'($urandom_range(0, 3));
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	// Offers one request transaction after a random gap and waits for it to be taken.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch);
		int gap;
		gap = gap_len();
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid     = 1'b0;
			req_ch.operation = OP_W'($urandom_range(0, 3));
			req_ch.character = CHAR_W'($urandom_range(0, 255));
		end
		@(negedge clk);
		req_ch.valid     = 1'b1;
		req_ch.operation = op;
		req_ch.character = ch;
		do
			@(posedge clk);
		while (!req_ch.ready);
		track_edit_distance(op, ch);
		if (op != OP_UNUSED)
			accepted_count++;
	endtask

	task automatic release_request();
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	// Holds the sender back until every owed distance has come out.
	task automatic wait_results_drained();
		release_request();
		while (distance_expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Loads both strings and ends the pair; a noisy pair has stray transactions mixed in.
	task automatic send_pair(input int len_a, input int len_b, input bit narrow, input bit noisy);
		for (int i = 0; i < len_a; i++)
			send_request(OP_FIRST, pick_char(narrow));
		for (int i = 0; i < len_b; i++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_request($urandom_range(0, 1) ? OP_UNUSED : OP_FIRST, pick_char(narrow));
			send_request(OP_SECOND, pick_char(narrow));
		end
		send_request(OP_END, pick_char(1'b0));
	endtask

	// Empty strings, the extreme bytes, every operation and a late first-string byte.
	task automatic test_directed();
		send_request(OP_END, 8'h00);
		send_request(OP_UNUSED, 8'hFF);
		send_request(OP_END, 8'h00);
		send_request(OP_FIRST, 8'h00);
		send_request(OP_FIRST, 8'hFF);
		send_request(OP_END, 8'hFF);
		send_request(OP_SECOND, 8'hFF);
		send_request(OP_SECOND, 8'h00);
		send_request(OP_SECOND, 8'hAA);
		send_request(OP_END, 8'h55);
		send_request(OP_FIRST, 8'h00);
		send_request(OP_FIRST, 8'hFF);
		send_request(OP_SECOND, 8'hFF);
		send_request(OP_SECOND, 8'h00);
		send_request(OP_END, 8'h00);
		send_request(OP_FIRST, 8'h61);
		send_request(OP_SECOND, 8'h61);
		send_request(OP_FIRST, 8'h62);
		send_request(OP_UNUSED, 8'h00);
		send_request(OP_END, 8'h00);
		send_request(OP_END, 8'h00);
	endtask

	// A full first string against an empty one, and both strings beyond the limit.
	task automatic test_full_strings();
		send_pair(MAX_LEN, 0, 1'b0, 1'b0);
		send_pair(MAX_LEN + 2, MAX_LEN + 1, 1'b1, 1'b0);
	endtask

	// The receiver stops for a long stretch while short pairs keep coming, so the input stalls.
	task automatic test_output_backpressure();
		wait_results_drained();
		idle_on       = 1'b0;
		rsp_hold_left = 12 * (MAX_LEN + 2);
		for (int i = 0; i < 10; i++)
			send_pair($urandom_range(0, 3), $urandom_range(0, 3), 1'b1, 1'b0);
		wait_results_drained();
	endtask

	// Mostly well-formed pairs with random content, otherwise stray transactions or a wait for the results to drain.
	task automatic test_random_sequences();
		int start_items;
		int r;
		int n;
		start_items = accepted_count;
		while (accepted_count - start_items < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 9) != 0);
			r       = $urandom_range(0, 99);
			if (r < 80) begin
				send_pair(pick_len(), pick_len(), 1'($urandom_range(0, 1)),
				          $urandom_range(0, 3) == 0);
			end else if (r < 95) begin
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++)
					send_request(OP_W'($urandom_range(0, 3)), pick_char(1'b0));
			end else begin
				wait_results_drained();
			end
		end
	endtask

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_left > 0) begin
				rsp_ch.ready = 1'b0;
				rsp_hold_left--;
			end else if (rsp_stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				rsp_stall_left--;
			end else begin
				rsp_ch.ready = 1'b1;
				if ($urandom_range(0, 99) < 30)
					rsp_stall_left = gap_len();
			end
		end
	end

	// Compares each result transaction with the oldest owed distance.
	always @(posedge clk) begin : result_check
		dist_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (distance_expected_q.size() == 0) begin
				$display("%0t: unexpected result distance %0d overflow %0b", $time,
				         rsp_ch.distance, rsp_ch.overflow);
				mismatch_count++;
			end else begin
				want = distance_expected_q.pop_front();
				if (rsp_ch.distance !== want.distance) begin
					$display("%0t: distance expected %0d actual %0d", $time,
					         want.distance, rsp_ch.distance);
					mismatch_count++;
				end
				if (rsp_ch.overflow !== want.overflow) begin
					$display("%0t: overflow expected %0b actual %0b", $time,
					         want.overflow, rsp_ch.overflow);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// Reset, then the tests in turn, then the verdict.
	initial begin
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_FIRST;
		req_ch.character = '0;
		clear_strings();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		idle_on = 1'b1;
		test_directed();
		test_full_strings();
		test_output_backpressure();
		test_random_sequences();
		wait_results_drained();

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
